### src/callsign_word_unpack_top_macros.svh
// assertion macros shared by the callsign unpacker
`ifndef CALLSIGN_WORD_UNPACK_TOP_MACROS_SVH
`define CALLSIGN_WORD_UNPACK_TOP_MACROS_SVH

// same-cycle implication, off while reset is high
`define CWU_ASSERT_IMPLIES(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// next-cycle implication, off while reset is high
`define CWU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`endif

### src/cwu_pkg.sv
package cwu_pkg;

   // code ranges
   localparam logic [27:0] CallLimit  = 28'd262177560;
   localparam logic [27:0] UpperLimit = 28'd267796946;
   localparam logic [27:0] CqPfxBase  = 28'd262178563;
   localparam logic [27:0] QrzPfxBase = 28'd264002072;
   localparam logic [27:0] DePfxBase  = 28'd265825581;
   localparam logic [27:0] CqSfxBase  = 28'd267649090;
   localparam logic [27:0] QrzSfxBase = 28'd267698375;
   localparam logic [27:0] DeSfxBase  = 28'd267747660;
   localparam logic [27:0] DeBareCode = 28'd267796945;

   // ascii
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] Char0     = 8'h30;
   localparam logic [7:0] Char3     = 8'h33;
   localparam logic [7:0] CharA     = 8'h41;
   localparam logic [7:0] CharD     = 8'h44;
   localparam logic [7:0] CharQ     = 8'h51;
   localparam logic [7:0] CharX     = 8'h58;

   // exact reciprocals: m = ceil(2^k / d), k = input bits + ceil(log2 d)
   localparam logic [63:0] One64 = 64'd1;
   // callsign word, 28-bit input
   localparam logic [5:0]  Shift27      = 6'd33;
   localparam logic [28:0] Recip27      = 29'(((One64 << 33) + 64'd26) / 64'd27);
   localparam logic [5:0]  Shift729     = 6'd38;
   localparam logic [28:0] Recip729     = 29'(((One64 << 38) + 64'd728) / 64'd729);
   localparam logic [5:0]  Shift19683   = 6'd43;
   localparam logic [28:0] Recip19683   = 29'(((One64 << 43) + 64'd19682) / 64'd19683);
   localparam logic [5:0]  Shift196830  = 6'd46;
   localparam logic [28:0] Recip196830  = 29'(((One64 << 46) + 64'd196829) / 64'd196830);
   localparam logic [5:0]  Shift7085880 = 6'd51;
   localparam logic [28:0] Recip7085880 =
      29'(((One64 << 51) + 64'd7085879) / 64'd7085880);
   // affix offset, 21-bit input
   localparam logic [5:0]  Shift37      = 6'd27;
   localparam logic [28:0] Recip37      = 29'(((One64 << 27) + 64'd36) / 64'd37);
   localparam logic [5:0]  Shift1369    = 6'd32;
   localparam logic [28:0] Recip1369    = 29'(((One64 << 32) + 64'd1368) / 64'd1369);
   localparam logic [5:0]  Shift50653   = 6'd37;
   localparam logic [28:0] Recip50653   = 29'(((One64 << 37) + 64'd50652) / 64'd50653);

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_CQ_PFX,
      MODE_QRZ_PFX,
      MODE_DE_PFX,
      MODE_CQ_SFX,
      MODE_QRZ_SFX,
      MODE_DE_SFX,
      MODE_DE_BARE
   } mode_type;

   typedef struct packed {
      logic [55:0] chars;
      logic [2:0]  length;
   } call_info_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] chars;
      logic [2:0]  length;
   } affix_info_type;

   // lowest member sits in the lowest bits
   typedef struct packed {
      mode_type    mode;
      logic [2:0]  affix_length;
      logic [31:0] affix_chars;
      logic [2:0]  call_length;
      logic [55:0] call_chars;
   } result_type;

   // floor(x / d) by reciprocal multiply
   function automatic logic [27:0] recip_quot(input logic [27:0] x, input logic [28:0] m,
                                              input logic [5:0] k);
      logic [56:0] prod;
      prod = 57'(x) * 57'(m);
      return 28'(prod >> k);
   endfunction

   // 0-9, A-Z, then space
   function automatic logic [7:0] sym_char(input logic [5:0] i);
      logic [7:0] c;
      priority if (i < 6'd10) begin
         c = Char0 + {2'b00, i};
      end else if (i < 6'd36) begin
         c = CharA + ({2'b00, i} - 8'd10);
      end else begin
         c = CharSpace;
      end
      return c;
   endfunction

endpackage

### src/cwu_call_decode.sv
module cwu_call_decode (
   input  logic [27:0]           code,
   output cwu_pkg::call_info_type call_info
);
   import cwu_pkg::*;

   logic [27:0] q1, q2, q3, q4, q5;
   logic [27:0] r5, r4, r3, r2, r1;
   logic [7:0]  w [6];
   logic [7:0]  t [6];
   logic [7:0]  u [7];
   logic        lead_space;
   logic        is_3d0;
   logic [2:0]  len;
   logic [55:0] chars;

   // quotients by running products of the radices
   assign q1 = recip_quot(code, Recip27, Shift27);
   assign q2 = recip_quot(code, Recip729, Shift729);
   assign q3 = recip_quot(code, Recip19683, Shift19683);
   assign q4 = recip_quot(code, Recip196830, Shift196830);
   assign q5 = recip_quot(code, Recip7085880, Shift7085880);

   assign r5 = code - 28'(q1 * 28'd27);
   assign r4 = q1 - 28'(q2 * 28'd27);
   assign r3 = q2 - 28'(q3 * 28'd27);
   assign r2 = q3 - 28'(q4 * 28'd10);
   assign r1 = q4 - 28'(q5 * 28'd36);

   always_comb begin
      w[0] = sym_char(q5[5:0]);
      w[1] = sym_char(r1[5:0]);
      w[2] = sym_char(r2[5:0]);
      w[3] = sym_char(r3[5:0] + 6'd10);
      w[4] = sym_char(r4[5:0] + 6'd10);
      w[5] = sym_char(r5[5:0] + 6'd10);
   end

   // only the first character can be a space at the front
   assign lead_space = (w[0] == CharSpace);

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         t[k] = lead_space ? w[k + 1] : w[k];
      end
      t[5] = lead_space ? CharSpace : w[5];
   end

   assign is_3d0 = (t[0] == Char3) && (t[1] == CharD) && (t[2] == Char0);

   always_comb begin
      priority if (code >= CallLimit) begin
         for (int k = 0; k < 6; k++) begin
            u[k] = CharDot;
         end
         u[6] = CharSpace;
      end else if (is_3d0) begin
         u[0] = Char3;
         u[1] = CharD;
         u[2] = CharA;
         u[3] = Char0;
         u[4] = t[3];
         u[5] = t[4];
         u[6] = t[5];
      end else if (t[0] == CharQ) begin
         u[0] = Char3;
         u[1] = CharX;
         for (int k = 1; k < 6; k++) begin
            u[k + 1] = t[k];
         end
      end else begin
         for (int k = 0; k < 6; k++) begin
            u[k] = t[k];
         end
         u[6] = CharSpace;
      end
   end

   // trailing trim: length ends at the last non-space
   always_comb begin
      len = 3'd0;
      for (int k = 0; k < 7; k++) begin
         if (u[k] != CharSpace) begin
            len = 3'(k + 1);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 7; k++) begin
         chars[55 - 8 * k -: 8] = u[k];
      end
   end

   assign call_info.chars  = chars;
   assign call_info.length = len;

endmodule

### src/cwu_affix_decode.sv
module cwu_affix_decode (
   input  logic [27:0]            code,
   output cwu_pkg::affix_info_type affix_info
);
   import cwu_pkg::*;

   mode_type    mode;
   logic [27:0] base;
   logic [20:0] offset;
   logic [27:0] q1, q2, q3;
   logic [27:0] e3, e2, e1;
   logic [7:0]  p [4];
   logic [7:0]  o [4];
   logic [1:0]  first;
   logic [1:0]  last;
   logic        any;
   logic [2:0]  len;
   logic [2:0]  idx;
   logic [31:0] chars;

   always_comb begin
      mode = MODE_PLAIN;
      base = '0;
      priority if (code >= CqPfxBase && code < QrzPfxBase) begin
         mode = MODE_CQ_PFX;
         base = CqPfxBase;
      end else if (code >= QrzPfxBase && code < DePfxBase) begin
         mode = MODE_QRZ_PFX;
         base = QrzPfxBase;
      end else if (code >= DePfxBase && code < CqSfxBase) begin
         mode = MODE_DE_PFX;
         base = DePfxBase;
      end else if (code >= CqSfxBase && code < QrzSfxBase) begin
         mode = MODE_CQ_SFX;
         base = CqSfxBase;
      end else if (code >= QrzSfxBase && code < DeSfxBase) begin
         mode = MODE_QRZ_SFX;
         base = QrzSfxBase;
      end else if (code >= DeSfxBase && code < DeBareCode) begin
         mode = MODE_DE_SFX;
         base = DeSfxBase;
      end else if (code == DeBareCode) begin
         mode = MODE_DE_BARE;
      end else begin
         mode = MODE_PLAIN;
      end
   end

   assign offset = 21'(code - base);

   // base-37 digits
   assign q1 = recip_quot({7'd0, offset}, Recip37, Shift37);
   assign q2 = recip_quot({7'd0, offset}, Recip1369, Shift1369);
   assign q3 = recip_quot({7'd0, offset}, Recip50653, Shift50653);
   assign e3 = {7'd0, offset} - 28'(q1 * 28'd37);
   assign e2 = q1 - 28'(q2 * 28'd37);
   assign e1 = q2 - 28'(q3 * 28'd37);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         p[k] = CharSpace;
      end
      if (mode == MODE_CQ_PFX || mode == MODE_QRZ_PFX || mode == MODE_DE_PFX) begin
         p[0] = sym_char(q3[5:0]);
         p[1] = sym_char(e1[5:0]);
         p[2] = sym_char(e2[5:0]);
         p[3] = sym_char(e3[5:0]);
      end else if (mode == MODE_CQ_SFX || mode == MODE_QRZ_SFX || mode == MODE_DE_SFX) begin
         p[0] = sym_char(e1[5:0]);
         p[1] = sym_char(e2[5:0]);
         p[2] = sym_char(e3[5:0]);
      end
   end

   // trim both ends
   always_comb begin
      first = 2'd0;
      last  = 2'd0;
      any   = 1'b0;
      for (int k = 3; k >= 0; k--) begin
         if (p[k] != CharSpace) begin
            first = 2'(k);
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (p[k] != CharSpace) begin
            last = 2'(k);
            any  = 1'b1;
         end
      end
   end

   assign len = any ? ({1'b0, last} - {1'b0, first} + 3'd1) : 3'd0;

   always_comb begin
      idx = 3'd0;
      for (int k = 0; k < 4; k++) begin
         idx = {1'b0, first} + 3'(k);
         o[k] = (idx < 3'd4) ? p[idx[1:0]] : CharSpace;
         chars[31 - 8 * k -: 8] = o[k];
      end
   end

   assign affix_info.mode   = mode;
   assign affix_info.chars  = chars;
   assign affix_info.length = len;

endmodule

### src/callsign_word_unpack_top.sv
// path: a request accept loads the input register, whose decode then loads the result register
// (rsp_tvalid rises once the result register is loaded; a stall can hold the input register)
// throughput: one request per cycle while rsp_tready is high; the decode is one pass of reciprocal multiplies
// rsp_tready low stalls the result register, and the input register fills behind it
// reset: synchronous, active high; clears both valid flags, data registers are not reset
`include "callsign_word_unpack_top_macros.svh"

module callsign_word_unpack_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // code[27:0], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // call_chars[55:0], call_length[58:56],
                                     // affix_chars[90:59], affix_length[93:91],
                                     // mode[96:94], zero pad
);
   import cwu_pkg::*;

   logic           stage_valid_ff, stage_valid_in;
   logic [27:0]    stage_code_ff, stage_code_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     result_ff, result_in;
   logic           slot_free;
   logic           stage_move;
   logic           req_accept;
   call_info_type  call_info;
   affix_info_type affix_info;
   logic           rsp_no_affix;
   logic           rsp_has_mode;
   logic           call_dotted;

   cwu_call_decode u_call (
      .code      (stage_code_ff),
      .call_info (call_info)
   );

   cwu_affix_decode u_affix (
      .code       (stage_code_ff),
      .affix_info (affix_info)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign stage_move = stage_valid_ff && slot_free;
   assign req_tready = !stage_valid_ff || slot_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_code_in  = stage_code_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
         stage_code_in  = req_tdata[27:0];
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (stage_move) begin
         rsp_valid_in           = 1'b1;
         result_in.mode         = affix_info.mode;
         result_in.affix_length = affix_info.length;
         result_in.affix_chars  = affix_info.chars;
         result_in.call_length  = call_info.length;
         result_in.call_chars   = call_info.chars;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_code_ff <= stage_code_in;
      result_ff     <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, result_ff};

   assign rsp_no_affix = rsp_tvalid &&
                         (result_ff.mode == MODE_PLAIN || result_ff.mode == MODE_DE_BARE);
   assign rsp_has_mode = rsp_tvalid && result_ff.mode != MODE_PLAIN;
   assign call_dotted  = result_ff.call_length == 3'd6 &&
                         result_ff.call_chars[55:48] == CharDot;

   `CWU_ASSERT_NEXT(a_accept_fills_stage, req_accept, stage_valid_ff)
   `CWU_ASSERT_NEXT(a_stage_reaches_rsp, stage_move, rsp_tvalid)
   `CWU_ASSERT_IMPLIES(a_no_affix_length, rsp_no_affix, result_ff.affix_length == 3'd0)
   `CWU_ASSERT_IMPLIES(a_upper_call_dots, rsp_has_mode, call_dotted)

endmodule

### test/unpack_checker.sv
module unpack_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   output int           fail_count,
   output int           pending,
   output int           checked,
   output int           affix_seen
);
   import cwu_pkg::*;

   typedef struct packed {
      logic [27:0] code;
      result_type  want;
   } expected_call_type;

   expected_call_type expected_calls[$];

   function automatic logic [7:0] symbol(input int unsigned i);
      if (i < 10) return Char0 + 8'(i);
      if (i < 36) return CharA + 8'(i - 10);
      return CharSpace;
   endfunction

   function automatic logic [7:0][7:0] base37_chars(input int unsigned v, input int count);
      logic [7:0][7:0] s;
      int k;
      s = {8{CharSpace}};
      for (k = count - 1; k > 0; k--) begin
         s[k] = symbol(v % 37);
         v = v / 37;
      end
      s[0] = symbol(v);
      return s;
   endfunction

   // strip spaces at both ends, first char lands in the top byte
   function automatic void squeeze_chars(input logic [7:0][7:0] str, input int n,
                                         input int slots, output logic [55:0] chars,
                                         output logic [2:0] count);
      int b, e, k;
      b = 0;
      e = n;
      while (b < e && str[b] == CharSpace) b++;
      while (e > b && str[e - 1] == CharSpace) e--;
      if (e - b > slots) e = b + slots;
      chars = '0;
      for (k = 0; k < slots; k++) begin
         chars = {chars[47:0], (b + k < e) ? str[b + k] : CharSpace};
      end
      count = 3'(e - b);
   endfunction

   function automatic result_type decode_callsign_word(input logic [27:0] code);
      logic [7:0][7:0] raw, shifted, word, afx;
      logic [55:0] chars;
      int unsigned v, lead, len, i;
      result_type r;
      raw = {8{CharDot}};
      afx = {8{CharSpace}};
      shifted = {8{CharSpace}};
      word = {8{CharSpace}};
      lead = 0;
      len = 6;
      r = '0;
      r.mode = MODE_PLAIN;
      if (code < CallLimit) begin
         v = 32'(code);
         raw[5] = symbol(v % 27 + 10); v = v / 27;
         raw[4] = symbol(v % 27 + 10); v = v / 27;
         raw[3] = symbol(v % 27 + 10); v = v / 27;
         raw[2] = symbol(v % 10);      v = v / 10;
         raw[1] = symbol(v % 36);      v = v / 36;
         raw[0] = symbol(v);
         while (lead < 4 && raw[lead] == CharSpace) lead++;
      end else if (code < UpperLimit) begin
         if (code == DeBareCode) begin
            r.mode = MODE_DE_BARE;
         end else if (code >= DeSfxBase) begin
            r.mode = MODE_DE_SFX;
            afx = base37_chars(32'(code - DeSfxBase), 3);
         end else if (code >= QrzSfxBase) begin
            r.mode = MODE_QRZ_SFX;
            afx = base37_chars(32'(code - QrzSfxBase), 3);
         end else if (code >= CqSfxBase) begin
            r.mode = MODE_CQ_SFX;
            afx = base37_chars(32'(code - CqSfxBase), 3);
         end else if (code >= DePfxBase) begin
            r.mode = MODE_DE_PFX;
            afx = base37_chars(32'(code - DePfxBase), 4);
         end else if (code >= QrzPfxBase) begin
            r.mode = MODE_QRZ_PFX;
            afx = base37_chars(32'(code - QrzPfxBase), 4);
         end else if (code >= CqPfxBase) begin
            r.mode = MODE_CQ_PFX;
            afx = base37_chars(32'(code - CqPfxBase), 4);
         end
      end
      len = 6 - lead;
      for (i = 0; i < len; i++) shifted[i] = raw[lead + i];
      // 3D0 and Q prefix rewrites
      if (len >= 3 && shifted[0] == Char3 && shifted[1] == CharD && shifted[2] == Char0) begin
         word[0] = Char3;
         word[1] = CharD;
         word[2] = CharA;
         word[3] = Char0;
         for (i = 3; i < len; i++) word[i + 1] = shifted[i];
         len++;
      end else if (len >= 1 && shifted[0] == CharQ) begin
         word[0] = Char3;
         word[1] = CharX;
         for (i = 1; i < len; i++) word[i + 1] = shifted[i];
         len++;
      end else begin
         word = shifted;
      end
      squeeze_chars(word, len, 7, r.call_chars, r.call_length);
      squeeze_chars(afx, 4, 4, chars, r.affix_length);
      r.affix_chars = chars[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want, input logic [27:0] code);
      $display("mismatch in %s for code %0d: got %h, expected %h", what, code, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      expected_call_type head;
      result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[96:0]);
            if (expected_calls.size() == 0) begin
               report_mismatch("result with no request pending", rsp_tdata[63:0], '0, '0);
            end else begin
               head = expected_calls.pop_front();
               if (got.call_chars !== head.want.call_chars)
                  report_mismatch("call_chars", 64'(got.call_chars),
                                  64'(head.want.call_chars), head.code);
               if (got.call_length !== head.want.call_length)
                  report_mismatch("call_length", 64'(got.call_length),
                                  64'(head.want.call_length), head.code);
               if (got.affix_chars !== head.want.affix_chars)
                  report_mismatch("affix_chars", 64'(got.affix_chars),
                                  64'(head.want.affix_chars), head.code);
               if (got.affix_length !== head.want.affix_length)
                  report_mismatch("affix_length", 64'(got.affix_length),
                                  64'(head.want.affix_length), head.code);
               if (got.mode !== head.want.mode)
                  report_mismatch("mode", 64'(got.mode), 64'(head.want.mode), head.code);
               if (rsp_tdata[103:97] !== 7'd0)
                  report_mismatch("padding", 64'(rsp_tdata[103:97]), '0, head.code);
               checked++;
               if (head.want.mode != MODE_PLAIN && head.want.mode != MODE_DE_BARE) affix_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            head.code = req_tdata[27:0];
            head.want = decode_callsign_word(req_tdata[27:0]);
            expected_calls.push_back(head);
         end
         pending <= expected_calls.size();
      end
   end

endmodule

### test/tb_top.sv
module tb_top;
   import cwu_pkg::*;

   localparam int RandomItems = 1700;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int sent = 0;
   int fail_count, pending, checked, affix_seen;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   callsign_word_unpack_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   unpack_checker word_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .affix_seen (affix_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // digit indexes most significant first; the last three are 0..25 letters, 26 space
   function automatic logic [27:0] call_code(input int unsigned c0, c1, c2, c3, c4, c5);
      return 28'(((((c0 * 36 + c1) * 10 + c2) * 27 + c3) * 27 + c4) * 27 + c5);
   endfunction

   function automatic logic [27:0] random_code();
      int unsigned sel, lo, hi, l3, l4, l5;
      logic [27:0] code;
      sel = $urandom_range(99);
      l3 = ($urandom_range(2) == 0) ? 26 : $urandom_range(26);
      l4 = ($urandom_range(2) == 0) ? 26 : $urandom_range(26);
      l5 = ($urandom_range(2) == 0) ? 26 : $urandom_range(26);
      if (sel < 45) begin
         code = 28'($urandom_range(CallLimit - 1, 0));
      end else if (sel < 57) begin
         case ($urandom_range(2))
            0: code = call_code(3, 13, 0, l3, l4, l5);
            1: code = call_code(26, $urandom_range(35), $urandom_range(9), l3, l4, l5);
            default: code = call_code(36, ($urandom_range(3) == 0) ? 26 : $urandom_range(35),
                                      $urandom_range(9), l3, l4, l5);
         endcase
      end else if (sel < 87) begin
         case ($urandom_range(5))
            0: begin lo = 32'(CqPfxBase);  hi = QrzPfxBase - 1; end
            1: begin lo = 32'(QrzPfxBase); hi = DePfxBase - 1; end
            2: begin lo = 32'(DePfxBase);  hi = CqSfxBase - 1; end
            3: begin lo = 32'(CqSfxBase);  hi = QrzSfxBase - 1; end
            4: begin lo = 32'(QrzSfxBase); hi = DeSfxBase - 1; end
            default: begin lo = 32'(DeSfxBase); hi = DeBareCode - 1; end
         endcase
         code = 28'($urandom_range(hi, lo));
      end else if (sel < 91) begin
         case ($urandom_range(2))
            0: code = 28'($urandom_range(CqPfxBase - 1, CallLimit));
            1: code = 28'($urandom_range(28'hFFFFFFF, UpperLimit));
            default: code = DeBareCode;
         endcase
      end else begin
         code = 28'($urandom());
      end
      return code;
   endfunction

   task automatic send_code(input logic [27:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // no progress on either channel for too long
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < StallLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
      end
      $display("watchdog: no request or result moved for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [27:0] directed_codes[$];
      int n;
      directed_codes = '{
         28'd0, CallLimit - 28'd1,
         call_code(3, 13, 0, 26, 26, 26), call_code(3, 13, 0, 0, 1, 2),
         call_code(26, 1, 2, 0, 26, 26), call_code(36, 26, 5, 1, 26, 2),
         call_code(10, 0, 0, 26, 0, 26),
         CallLimit, CqPfxBase - 28'd1, CqPfxBase, CqPfxBase + 28'd36, QrzPfxBase - 28'd1,
         QrzPfxBase, DePfxBase, CqSfxBase - 28'd1, CqSfxBase, QrzSfxBase - 28'd1,
         QrzSfxBase, DeSfxBase, DeBareCode - 28'd1, DeBareCode, UpperLimit, 28'hFFFFFFF
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 26;
      rsp_idle_pct  <= 70;
      foreach (directed_codes[i]) send_code(directed_codes[i]);
      drain_all();
      for (n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 3) begin
            send_idle_pct <= 70;
            rsp_idle_pct  <= 26;
         end else if (n == 2 * RandomItems / 3) begin
            send_idle_pct <= 0;
            rsp_idle_pct  <= 0;
         end
         send_code(random_code());
      end
      drain_all();
      repeat (DrainCycles) @(posedge clock);
      $display("decoded %0d callsign words under three sender/receiver stall mixes, %0d checked",
               sent, checked);
      $display("%0d carried a prefix or suffix, the rest plain, dotted or bare DE", affix_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/cwu_pkg.sv
src/cwu_call_decode.sv
src/cwu_affix_decode.sv
src/callsign_word_unpack_top.sv
test/unpack_checker.sv
test/tb_top.sv
